@@ rtl/box_blur_3x3_rgb_unit_assert.svh @@
// Assertion macros for the 3x3 RGB box blur unit.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef BOX_BLUR_3X3_RGB_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent
`define BBR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent
`define BBR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bbr_pkg.sv @@
// Shared constants, codes and types of the 3x3 RGB box blur unit.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package bbr_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 1024;
	localparam int MIN_WIDTH    = 3;
	localparam int MIN_HEIGHT   = 1;
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	// pixel ring: two rows plus three pixels
	localparam int STORE_DEPTH = 2 * MAX_WIDTH + 3;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	// pixel counts run up to and including the frame size
	localparam int CNT_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	// signed linear position of a tap
	localparam int POS_W       = CNT_W + 1;
	// signed tap offset and unwrapped ring address
	localparam int OFF_W       = ADDR_W + 2;

	localparam int DIM_W       = 11;
	localparam int CFG_IDX_W   = 1;
	localparam int COLOR_W     = 8;
	localparam int PIXEL_W     = 3 * COLOR_W;
	localparam int LANES       = 3;
	localparam int TAPS        = 9;
	localparam int SUM_W       = $clog2(TAPS * ((1 << COLOR_W) - 1) + 1);
	localparam int TAP_CNT_W   = $clog2(TAPS + 1);
	localparam int DIV_STEPS   = COLOR_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic {
		ACT_PUSH  = 1'b0,
		ACT_DRAIN = 1'b1
	} action_t;

	typedef struct packed {
		logic               action;
		logic [COLOR_W-1:0] red_in;
		logic [COLOR_W-1:0] green_in;
		logic [COLOR_W-1:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red_out;
		logic [COLOR_W-1:0] green_out;
		logic [COLOR_W-1:0] blue_out;
		logic               frame_end;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic take;       // input transfer this cycle
		logic tap_start;  // clear accumulators and tap walk
		logic tap_issue;  // read one neighbor
		logic div_step;   // one quotient bit per lane
		logic load_out;   // move result into output register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic skip_item;   // push into a full frame: no work, no result
		logic emit_ok;     // oldest pending result has all its neighbors
		logic tap_last;
		logic div_last;
		logic out_free;
		logic frame_done;  // pending result is the last of the frame
		logic counts_zero;
	} dp_status_t;

endpackage

`default_nettype wire

@@ rtl/bbr_ifs.sv @@
// Valid/ready channel interfaces for pixel input and blurred output.
// Depends on bbr_pkg for the payload types.
`default_nettype none

interface bbr_in_if;
	import bbr_pkg::*;

	logic               valid;
	logic               ready;
	logic               action;
	logic [COLOR_W-1:0] red_in;
	logic [COLOR_W-1:0] green_in;
	logic [COLOR_W-1:0] blue_in;

	modport source (output valid, action, red_in, green_in, blue_in, input ready);
	modport sink (input valid, action, red_in, green_in, blue_in, output ready);
endinterface

interface bbr_out_if;
	import bbr_pkg::*;

	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] red_out;
	logic [COLOR_W-1:0] green_out;
	logic [COLOR_W-1:0] blue_out;
	logic               frame_end;

	modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
	modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

`default_nettype wire

@@ rtl/bbr_ctrl.sv @@
// Sequencer of the box blur: accept, check, nine tap reads, divide, emit.
// Depends on bbr_pkg for command and status structs.
`default_nettype none

module bbr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  var  bbr_pkg::dp_status_t status,
	output bbr_pkg::ctrl_cmd_t       cmd
);
	import bbr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TAP,
		ST_FLUSH,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	// commands decoded from state and status
	always_comb begin
		cmd           = '0;
		cmd.take      = in_valid && (state_q == ST_IDLE);
		cmd.tap_start = (state_q == ST_CHECK) && status.emit_ok;
		cmd.tap_issue = (state_q == ST_TAP);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.load_out  = (state_q == ST_EMIT) && status.out_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= status.skip_item ? ST_IDLE : ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= status.emit_ok ? ST_TAP : ST_IDLE;
				end
				ST_TAP: begin
					if (status.tap_last) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (status.div_last) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/bbr_dp.sv @@
// Datapath of the box blur: config, pixel ring memory, tap walk,
// per-lane accumulate, bit-serial divide and output register.
// Depends on bbr_pkg.
`default_nettype none

module bbr_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [bbr_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [bbr_pkg::DIM_W-1:0]     wr_data,
	input  var  bbr_pkg::in_item_t             px_in,
	input  var  bbr_pkg::ctrl_cmd_t            cmd,
	input  wire logic                          out_ready,
	output bbr_pkg::dp_status_t                status,
	output bbr_pkg::out_item_t                 out_item,
	output logic                               out_valid
);
	import bbr_pkg::*;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] lo, input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] r;
		r = v;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] ring_inc(input logic [ADDR_W-1:0] p);
		logic [ADDR_W-1:0] r;
		r = (p == ADDR_W'(STORE_DEPTH - 1)) ? '0 : p + ADDR_W'(1);
		return r;
	endfunction

	// frame geometry (clamped on write)
	logic [DIM_W-1:0]   width_q, height_q;
	logic [2*DIM_W-1:0] area;
	logic [CNT_W-1:0]   total_q;

	// frame progress
	logic [CNT_W-1:0]  pushed_q, emitted_q, emit_next;
	logic [ADDR_W-1:0] wr_ptr_q, rd_base_q;
	logic [POS_W-1:0]  reach;
	logic              room, push_en, frame_done;

	// tap walk
	logic [1:0]              row_q, col_q;
	logic signed [OFF_W-1:0] row_off, col_off, tap_off;
	logic signed [OFF_W-1:0] addr_sum, addr_lo, addr_hi;
	logic [ADDR_W-1:0]       tap_addr;
	logic signed [POS_W-1:0] tap_pos;
	logic                    tap_ok;

	// ring memory and read stage
	logic [PIXEL_W-1:0] store [STORE_DEPTH];
	logic [PIXEL_W-1:0] rd_data_s1;
	logic               tap_ok_s1;

	// accumulate and divide
	logic [SUM_W-1:0]     sum_q   [LANES];
	logic [COLOR_W-1:0]   quo_q   [LANES];
	logic [SUM_W-1:0]     sum_nxt [LANES];
	logic [LANES-1:0]     quo_bit;
	logic [SUM_W-1:0]     div_cmp;
	logic [TAP_CNT_W-1:0] tap_cnt_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	out_item_t out_q;
	logic      out_valid_q;

	assign area = width_q * height_q;

	// push bookkeeping
	assign room      = pushed_q < total_q;
	assign push_en   = cmd.take && (px_in.action == ACT_PUSH) && room;
	assign emit_next = emitted_q + CNT_W'(1);
	assign frame_done = (emit_next == total_q);

	// oldest result is complete once pixel e+w+1 is in, or the frame is in
	assign reach = {1'b0, emitted_q} + POS_W'(width_q) + POS_W'(1);

	// neighbor offset: row in {-w, 0, +w}, column in {-1, 0, +1}
	always_comb begin
		unique case (row_q)
			2'd0:    row_off = -$signed({{(OFF_W-DIM_W){1'b0}}, width_q});
			2'd2:    row_off = $signed({{(OFF_W-DIM_W){1'b0}}, width_q});
			default: row_off = '0;
		endcase
		col_off = $signed({{(OFF_W-2){1'b0}}, col_q}) - $signed(OFF_W'(1));
		tap_off = row_off + col_off;
	end

	// ring address: one wrap correction either way
	always_comb begin
		addr_sum = $signed({2'b00, rd_base_q}) + tap_off;
		addr_lo  = addr_sum + $signed(OFF_W'(STORE_DEPTH));
		addr_hi  = addr_sum - $signed(OFF_W'(STORE_DEPTH));
		if (addr_sum < 0) begin
			tap_addr = addr_lo[ADDR_W-1:0];
		end else if (addr_sum >= $signed(OFF_W'(STORE_DEPTH))) begin
			tap_addr = addr_hi[ADDR_W-1:0];
		end else begin
			tap_addr = addr_sum[ADDR_W-1:0];
		end
	end

	// neighbor inside the frame buffer
	assign tap_pos = $signed({1'b0, emitted_q}) +
		$signed({{(POS_W-OFF_W){tap_off[OFF_W-1]}}, tap_off});
	assign tap_ok  = !tap_pos[POS_W-1] && (tap_pos < $signed({1'b0, total_q}));

	// restoring divide step, all lanes by the same tap count
	assign div_cmp = SUM_W'(tap_cnt_q) << (DIV_CNT_W'(DIV_STEPS - 1) - div_cnt_q);

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			quo_bit[i] = sum_q[i] >= div_cmp;
			sum_nxt[i] = quo_bit[i] ? sum_q[i] - div_cmp : sum_q[i];
		end
	end

	// pixel ring: write on push, registered read per tap
	always_ff @(posedge clk) begin
		if (push_en) begin
			store[wr_ptr_q] <= {px_in.red_in, px_in.green_in, px_in.blue_in};
		end
		if (cmd.tap_issue) begin
			rd_data_s1 <= store[tap_addr];
		end
	end

	// config, counters, accumulators, divider, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= DIM_W'(WIDTH_RESET);
			height_q    <= DIM_W'(HEIGHT_RESET);
			total_q     <= CNT_W'(WIDTH_RESET * HEIGHT_RESET);
			pushed_q    <= '0;
			emitted_q   <= '0;
			wr_ptr_q    <= '0;
			rd_base_q   <= '0;
			row_q       <= '0;
			col_q       <= '0;
			tap_ok_s1   <= 1'b0;
			tap_cnt_q   <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int i = 0; i < LANES; i++) begin
				sum_q[i] <= '0;
				quo_q[i] <= '0;
			end
		end else begin
			total_q   <= area[CNT_W-1:0];
			tap_ok_s1 <= cmd.tap_issue && tap_ok;

			if (wr_en) begin
				unique case (reg_idx_t'(wr_index))
					REG_FRAME_WIDTH: begin
						width_q <= clamp_dim(wr_data, DIM_W'(MIN_WIDTH), DIM_W'(MAX_WIDTH));
					end
					REG_FRAME_HEIGHT: begin
						height_q <= clamp_dim(wr_data, DIM_W'(MIN_HEIGHT),
							DIM_W'(MAX_HEIGHT));
					end
					default: begin
						width_q <= width_q;
					end
				endcase
				pushed_q  <= '0;
				emitted_q <= '0;
				wr_ptr_q  <= '0;
				rd_base_q <= '0;
			end

			if (push_en) begin
				pushed_q <= pushed_q + CNT_W'(1);
				wr_ptr_q <= ring_inc(wr_ptr_q);
			end

			// tap walk and accumulate (accumulate follows the registered read)
			if (cmd.tap_start) begin
				row_q     <= '0;
				col_q     <= '0;
				tap_cnt_q <= '0;
				div_cnt_q <= '0;
				for (int i = 0; i < LANES; i++) begin
					sum_q[i] <= '0;
				end
			end else begin
				if (cmd.tap_issue) begin
					if (col_q == 2'd2) begin
						col_q <= '0;
						row_q <= row_q + 2'd1;
					end else begin
						col_q <= col_q + 2'd1;
					end
				end
				if (tap_ok_s1) begin
					tap_cnt_q <= tap_cnt_q + TAP_CNT_W'(1);
					for (int i = 0; i < LANES; i++) begin
						sum_q[i] <= sum_q[i] +
							SUM_W'(rd_data_s1[(LANES-1-i)*COLOR_W +: COLOR_W]);
					end
				end
				if (cmd.div_step) begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					for (int i = 0; i < LANES; i++) begin
						sum_q[i] <= sum_nxt[i];
						quo_q[i] <= {quo_q[i][COLOR_W-2:0], quo_bit[i]};
					end
				end
			end

			// result transfer and frame progress
			if (cmd.load_out) begin
				out_valid_q     <= 1'b1;
				out_q.red_out   <= quo_q[0];
				out_q.green_out <= quo_q[1];
				out_q.blue_out  <= quo_q[2];
				out_q.frame_end <= frame_done;
				if (emit_next >= total_q) begin
					pushed_q  <= '0;
					emitted_q <= '0;
					wr_ptr_q  <= '0;
					rd_base_q <= '0;
				end else begin
					emitted_q <= emit_next;
					rd_base_q <= ring_inc(rd_base_q);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// status to controller
	always_comb begin
		status             = '0;
		status.skip_item   = (px_in.action == ACT_PUSH) && !room;
		status.emit_ok     = (emitted_q < pushed_q) &&
			((reach < {1'b0, pushed_q}) || (pushed_q >= total_q));
		status.tap_last    = (row_q == 2'd2) && (col_q == 2'd2);
		status.div_last    = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
		status.out_free    = !out_valid_q || out_ready;
		status.frame_done  = frame_done;
		status.counts_zero = (pushed_q == '0) && (emitted_q == '0);
	end

	assign out_item  = out_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/box_blur_3x3_rgb_unit.sv @@
// Top level of the 3x3 RGB box blur: controller, datapath, assertions.
// Depends on bbr_pkg, bbr_ifs and box_blur_3x3_rgb_unit_assert.svh.
//
//   port      dir  kind          carries
//   pixels    in   valid/ready   action, red_in, green_in, blue_in
//   results   out  valid/ready   red_out, green_out, blue_out, frame_end
//   wr_*      in   write strobe  frame_width (index 0), frame_height (index 1)
//
// One item at a time. A push or drain without a result goes through transfer and
// check; a push into a full frame stops at transfer. An item with a result goes
// through transfer, check, 9 ring reads, 1 accumulate, 8 divide steps, output load.
// The load stalls while the output register holds an untaken result; once loaded,
// the input side is free again while the result waits for transfer.
// Reset sets the geometry to 640x480 and clears counts; the ring is not cleared.
`default_nettype none
`include "box_blur_3x3_rgb_unit_assert.svh"

module box_blur_3x3_rgb_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [bbr_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [bbr_pkg::DIM_W-1:0]     wr_data,
	bbr_in_if.sink                             pixels,
	bbr_out_if.source                          results
);
	import bbr_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	in_item_t   px_in;
	out_item_t  out_item;
	logic       out_valid;

	assign px_in.action   = pixels.action;
	assign px_in.red_in   = pixels.red_in;
	assign px_in.green_in = pixels.green_in;
	assign px_in.blue_in  = pixels.blue_in;

	bbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_ready (pixels.ready),
		.status   (status),
		.cmd      (cmd)
	);

	bbr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.px_in     (px_in),
		.cmd       (cmd),
		.out_ready (results.ready),
		.status    (status),
		.out_item  (out_item),
		.out_valid (out_valid)
	);

	assign results.valid     = out_valid;
	assign results.red_out   = out_item.red_out;
	assign results.green_out = out_item.green_out;
	assign results.blue_out  = out_item.blue_out;
	assign results.frame_end = out_item.frame_end;

	// a pending result is never overwritten
	`BBR_ASSERT_NOW(a_load_into_free, cmd.load_out, status.out_free, "result overwritten")
	// a loaded result is offered on the next cycle
	`BBR_ASSERT_NEXT(a_load_shows, cmd.load_out, results.valid, "loaded result not offered")
	// the last result of a frame restarts the frame
	`BBR_ASSERT_NEXT(a_frame_restart, cmd.load_out && status.frame_done, status.counts_zero,
		"frame counts not cleared after last result")

endmodule

`default_nettype wire
